FILE: hdl/ppmd_pkg.sv
// Shared types and constants for the PPM stream decoder.
// No dependencies.
package ppmd_pkg;

    localparam int DIM_BITS  = 12;
    localparam int CNT_BITS  = 2 * DIM_BITS;
    localparam int QDEPTH    = 2;
    localparam int QAW       = $clog2(QDEPTH);

    localparam logic [15:0] ACC_MAX = 16'hFFFF;
    localparam logic [DIM_BITS-1:0] DIM_MAX = {DIM_BITS{1'b1}};
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_P     = 8'd80;
    localparam logic [7:0] CH_THREE = 8'd51;
    localparam logic [7:0] CH_SIX   = 8'd54;
    localparam logic [7:0] SAMP_MAX = 8'd255;

    localparam logic [1:0] CHAN_RED   = 2'd0;
    localparam logic [1:0] CHAN_GREEN = 2'd1;
    localparam logic [1:0] CHAN_BLUE  = 2'd2;

    typedef enum logic [6:0] {
        PH_MAGIC1 = 7'b0000001,
        PH_MAGIC2 = 7'b0000010,
        PH_WIDTH  = 7'b0000100,
        PH_HEIGHT = 7'b0001000,
        PH_MAXVAL = 7'b0010000,
        PH_PIXELS = 7'b0100000,
        PH_DONE   = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [15:0] value;
        logic [15:0] maxval;
        logic [1:0]  chan;
        logic        final_px;
        logic        ascii;
    } t_sample;

endpackage

FILE: hdl/ppmd_front.sv
// Header parser and sample classifier of the PPM stream decoder.
// Depends on ppmd_pkg.
module ppmd_front import ppmd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_file_byte,
    input  logic          i_start_of_file,
    input  logic          i_q_full,
    output logic          o_push,
    output t_sample       o_sample
);

    t_phase                r_phase, n_phase;
    logic                  r_ascii, n_ascii;
    logic [DIM_BITS-1:0]   r_width, n_width;
    logic [DIM_BITS-1:0]   r_height, n_height;
    logic [15:0]           r_max, n_max;
    logic [15:0]           r_acc, n_acc;
    logic                  r_digits, n_digits;
    logic [1:0]            r_chan, n_chan;
    logic [CNT_BITS-1:0]   r_remain, n_remain;

    t_phase                c_phase;
    logic                  c_digits;
    logic [15:0]           c_acc;
    logic [1:0]            c_chan;
    logic                  take;
    logic                  is_dig;
    logic [19:0]           prod;
    logic [15:0]           num_next;
    logic [DIM_BITS-1:0]   dim_val;
    logic                  push;
    logic [15:0]           push_val;
    logic                  last_px;

    assign o_ready = !i_q_full;
    assign take    = i_valid && !i_q_full;
    assign is_dig  = (i_file_byte >= CH_ZERO) && (i_file_byte <= CH_NINE);

    always_comb begin
        c_phase  = i_start_of_file ? PH_MAGIC1 : r_phase;
        c_digits = i_start_of_file ? 1'b0 : r_digits;
        c_acc    = i_start_of_file ? 16'd0 : r_acc;
        c_chan   = i_start_of_file ? CHAN_RED : r_chan;
        prod     = {1'b0, c_acc, 3'b000} + {3'b000, c_acc, 1'b0}
                 + {12'd0, i_file_byte - CH_ZERO};
        num_next = (prod > {4'd0, ACC_MAX}) ? ACC_MAX : prod[15:0];
        dim_val  = ({1'b0, c_acc} > {{(17-DIM_BITS){1'b0}}, DIM_MAX})
                 ? DIM_MAX : c_acc[DIM_BITS-1:0];
        last_px  = (c_chan == CHAN_BLUE) && (r_remain == CNT_BITS'(1));
    end

    always_comb begin
        n_phase  = c_phase;
        n_ascii  = i_start_of_file ? 1'b0 : r_ascii;
        n_width  = i_start_of_file ? '0 : r_width;
        n_height = i_start_of_file ? '0 : r_height;
        n_max    = i_start_of_file ? '0 : r_max;
        n_acc    = c_acc;
        n_digits = c_digits;
        n_chan   = c_chan;
        n_remain = r_remain;
        push     = 1'b0;
        push_val = c_acc;
        unique case (c_phase)
            PH_MAGIC1: begin
                n_phase = (i_file_byte == CH_P) ? PH_MAGIC2 : PH_DONE;
            end
            PH_MAGIC2: begin
                if (i_file_byte == CH_THREE) begin
                    n_ascii = 1'b1;
                    n_phase = PH_WIDTH;
                end else if (i_file_byte == CH_SIX) begin
                    n_ascii = 1'b0;
                    n_phase = PH_WIDTH;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                if (is_dig) begin
                    n_acc    = num_next;
                    n_digits = 1'b1;
                end else if (c_digits) begin
                    n_acc    = '0;
                    n_digits = 1'b0;
                    if (c_phase == PH_WIDTH) begin
                        n_width = dim_val;
                        n_phase = PH_HEIGHT;
                    end else if (c_phase == PH_HEIGHT) begin
                        n_height = dim_val;
                        n_phase  = PH_MAXVAL;
                    end else begin
                        n_max    = c_acc;
                        n_remain = {{DIM_BITS{1'b0}}, r_width}
                                 * {{DIM_BITS{1'b0}}, r_height};
                        if (c_acc == 16'd0 || r_width == '0 || r_height == '0
                            || (!r_ascii && c_acc > 16'd255))
                            n_phase = PH_DONE;
                        else
                            n_phase = PH_PIXELS;
                    end
                end
            end
            PH_PIXELS: begin
                if (!r_ascii) begin
                    push     = 1'b1;
                    push_val = {8'd0, i_file_byte};
                end else if (is_dig) begin
                    n_acc    = num_next;
                    n_digits = 1'b1;
                end else if (c_digits) begin
                    push     = 1'b1;
                    n_acc    = '0;
                    n_digits = 1'b0;
                end
                if (push) begin
                    if (c_chan == CHAN_BLUE) begin
                        n_chan   = CHAN_RED;
                        n_remain = r_remain - CNT_BITS'(1);
                        if (last_px)
                            n_phase = PH_DONE;
                    end else begin
                        n_chan = c_chan + 2'd1;
                    end
                end
            end
            PH_DONE: begin
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    assign o_push            = take && push;
    assign o_sample.value    = push_val;
    assign o_sample.maxval   = r_max;
    assign o_sample.chan     = c_chan;
    assign o_sample.final_px = last_px;
    assign o_sample.ascii    = r_ascii;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC1;
            r_ascii  <= 1'b0;
            r_width  <= '0;
            r_height <= '0;
            r_max    <= '0;
            r_acc    <= '0;
            r_digits <= 1'b0;
            r_chan   <= CHAN_RED;
            r_remain <= '0;
        end else if (take) begin
            r_phase  <= n_phase;
            r_ascii  <= n_ascii;
            r_width  <= n_width;
            r_height <= n_height;
            r_max    <= n_max;
            r_acc    <= n_acc;
            r_digits <= n_digits;
            r_chan   <= n_chan;
            r_remain <= n_remain;
        end
    end

endmodule

FILE: hdl/ppmd_fifo.sv
// Two-entry sample queue between parser and scaler.
// Depends on ppmd_pkg.
module ppmd_fifo import ppmd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_sample  i_data,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_avail,
    output t_sample  o_data
);

    t_sample            r_mem [QDEPTH];
    logic [QAW-1:0]     r_wp, r_rp;
    logic [QAW:0]       r_cnt, n_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop)
            n_cnt = r_cnt + (QAW+1)'(1);
        else if (!i_push && i_pop)
            n_cnt = r_cnt - (QAW+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push)
                r_wp <= r_wp + QAW'(1);
            if (i_pop)
                r_rp <= r_rp + QAW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp] <= i_data;
    end

endmodule

FILE: hdl/ppmd_back.sv
// Sample scaler (serial divide) and pixel assembly with output register.
// Depends on ppmd_pkg.
module ppmd_back import ppmd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_avail,
    input  t_sample     i_sample,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_final_pixel,
    output logic        o_ascii_format
);

    logic          r_busy, r_fin;
    logic [2:0]    r_step;
    logic [23:0]   r_rem, r_dsh;
    logic [7:0]    r_q;
    logic          r_sat;
    logic [1:0]    r_chan;
    logic          r_final, r_ascii;
    logic [7:0]    r_hr, r_hg;
    logic          r_ov;
    logic [7:0]    r_r, r_g, r_b;
    logic          r_f, r_a;

    logic          out_free, deliver;
    logic [7:0]    scaled;

    assign o_pop    = !r_busy && i_avail;
    assign out_free = !r_ov || i_ready;
    assign deliver  = r_busy && r_fin && (r_chan != CHAN_BLUE || out_free);
    assign scaled   = r_sat ? SAMP_MAX : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (deliver && r_chan == CHAN_BLUE)
                r_ov <= 1'b1;
            else if (i_ready)
                r_ov <= 1'b0;
            if (o_pop) begin
                r_busy <= 1'b1;
                r_fin  <= 1'b0;
            end else if (r_busy && !r_fin) begin
                if (r_step == 3'd0)
                    r_fin <= 1'b1;
            end else if (deliver) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem   <= {i_sample.value, 8'd0} - {8'd0, i_sample.value};
            r_dsh   <= {1'b0, i_sample.maxval, 7'd0};
            r_sat   <= (i_sample.value >= i_sample.maxval);
            r_q     <= '0;
            r_step  <= 3'd7;
            r_chan  <= i_sample.chan;
            r_final <= i_sample.final_px;
            r_ascii <= i_sample.ascii;
        end else if (r_busy && !r_fin) begin
            if (r_rem >= r_dsh) begin
                r_rem        <= r_rem - r_dsh;
                r_q[r_step]  <= 1'b1;
            end
            r_dsh  <= {1'b0, r_dsh[23:1]};
            r_step <= r_step - 3'd1;
        end
        if (deliver) begin
            unique case (r_chan)
                CHAN_RED:   r_hr <= scaled;
                CHAN_GREEN: r_hg <= scaled;
                default: begin
                    r_r <= r_hr;
                    r_g <= r_hg;
                    r_b <= scaled;
                    r_f <= r_final;
                    r_a <= r_ascii;
                end
            endcase
        end
    end

    assign o_valid        = r_ov;
    assign o_red          = r_r;
    assign o_green        = r_g;
    assign o_blue         = r_b;
    assign o_final_pixel  = r_f;
    assign o_ascii_format = r_a;

endmodule

FILE: hdl/ppm_image_stream_decoder_top.sv
// PPM (P3/P6) stream decoder: one input byte per transfer, one RGB pixel out per triple.
// Each sample holds the scaler through dequeue, 8 divide steps and deliver, so it
// takes no new sample until the last one is delivered. Two-entry queue between.
// Synchronous active-low reset returns to expecting the first magic byte.
module ppm_image_stream_decoder_top import ppmd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_file_byte,
    input  logic        i_start_of_file,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_final_pixel,
    output logic        o_ascii_format
);

    logic     q_full, q_push, q_pop, q_avail;
    t_sample  q_in, q_out;

    ppmd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_file_byte     (i_file_byte),
        .i_start_of_file (i_start_of_file),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_sample        (q_in)
    );

    ppmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_data  (q_out)
    );

    ppmd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_avail        (q_avail),
        .i_sample       (q_out),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_final_pixel  (o_final_pixel),
        .o_ascii_format (o_ascii_format)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_avail)
        else $error("queue pop while empty");

    a_ready_tracks_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !o_ready)
        else $error("input ready while queue full");

endmodule

FILE: test/tb_ppm_image_stream_decoder_top.sv
// Testbench for ppm_image_stream_decoder_top: streams P3/P6 files byte by byte and
// checks every emitted pixel against an in-bench decoder model.
// Depends on ppmd_pkg and the decoder RTL.
module tb_ppm_image_stream_decoder_top;
    import ppmd_pkg::*;

    typedef struct packed {
        logic [7:0] fbyte;
        logic       sof;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
        logic       ascii;
    } t_pixel;

    typedef enum int { FMT_NONE, FMT_P3, FMT_P6 } t_fmt;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_file_byte = '0;
    logic        i_start_of_file = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_red, o_green, o_blue;
    logic        o_final_pixel, o_ascii_format;

    ppm_image_stream_decoder_top u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_in_item byte_q[$];
    t_pixel   pixel_q[$];
    int       n_errors = 0;
    int       n_items = 0;
    bit       quiet_tail = 1'b0;
    bit       hold_send = 1'b0;
    int       cycle_cnt = 0;

    // decoder model state
    t_phase       m_phase = PH_MAGIC1;
    t_fmt         m_fmt = FMT_NONE;
    int unsigned  m_w = 0, m_h = 0, m_max = 0, m_acc = 0;
    bit           m_digits = 0;
    int unsigned  m_chan = 0, m_red = 0, m_green = 0;
    longint unsigned m_count = 0;

    function automatic int unsigned clamp_dim(int unsigned v);
        return (v > DIM_MAX) ? DIM_MAX : v;
    endfunction

    function automatic int unsigned scale(int unsigned v);
        int unsigned q;
        if (m_max == 0) return 0;
        q = (v * 255) / m_max;
        return (q > 255) ? 255 : q;
    endfunction

    function automatic bit digit_step(int unsigned b);
        int unsigned n;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            n = m_acc * 10 + (b - CH_ZERO);
            m_acc = (n > ACC_MAX) ? ACC_MAX : n;
            m_digits = 1;
            return 0;
        end
        return m_digits;
    endfunction

    function automatic void push_sample(int unsigned s);
        t_pixel px;
        longint unsigned total;
        if (m_chan == 0) begin
            m_red = s;
            m_chan = 1;
        end else if (m_chan == 1) begin
            m_green = s;
            m_chan = 2;
        end else begin
            m_chan = 0;
            total = longint'(m_w) * longint'(m_h);
            m_count++;
            px.red = 8'(m_red);
            px.green = 8'(m_green);
            px.blue = 8'(s);
            px.last = (m_count >= total);
            px.ascii = (m_fmt == FMT_P3);
            pixel_q.push_back(px);
            if (m_count >= total) m_phase = PH_DONE;
        end
    endfunction

    function automatic void decode_byte(t_in_item it);
        int unsigned b;
        int unsigned v;
        b = it.fbyte;
        if (it.sof) begin
            m_phase = PH_MAGIC1; m_fmt = FMT_NONE; m_w = 0; m_h = 0; m_max = 0;
            m_acc = 0; m_digits = 0; m_chan = 0; m_red = 0; m_green = 0; m_count = 0;
        end
        case (m_phase)
            PH_MAGIC1: m_phase = (b == CH_P) ? PH_MAGIC2 : PH_DONE;
            PH_MAGIC2: begin
                if (b == CH_THREE) begin
                    m_fmt = FMT_P3; m_phase = PH_WIDTH;
                end else if (b == CH_SIX) begin
                    m_fmt = FMT_P6; m_phase = PH_WIDTH;
                end else begin
                    m_phase = PH_DONE;
                end
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                if (digit_step(b)) begin
                    if (m_phase == PH_WIDTH) begin
                        m_w = clamp_dim(m_acc); m_phase = PH_HEIGHT;
                    end else if (m_phase == PH_HEIGHT) begin
                        m_h = clamp_dim(m_acc); m_phase = PH_MAXVAL;
                    end else begin
                        m_max = m_acc;
                        if (m_max == 0 || m_w == 0 || m_h == 0 ||
                            (m_fmt == FMT_P6 && m_max > 255))
                            m_phase = PH_DONE;
                        else
                            m_phase = PH_PIXELS;
                    end
                    m_acc = 0;
                    m_digits = 0;
                end
            end
            PH_PIXELS: begin
                if (m_fmt == FMT_P6) begin
                    push_sample(scale(b));
                end else if (digit_step(b)) begin
                    v = m_acc;
                    m_acc = 0;
                    m_digits = 0;
                    push_sample(scale(v));
                end
            end
            default: ;
        endcase
    endfunction

    // stimulus builders
    function automatic void put_byte(int unsigned b, bit sof = 0);
        t_in_item it;
        it.fbyte = 8'(b);
        it.sof = sof;
        byte_q.push_back(it);
        n_items++;
    endfunction

    function automatic void put_text(string s, bit sof_first = 0);
        for (int i = 0; i < s.len(); i++) put_byte(s[i], sof_first && i == 0);
    endfunction

    function automatic int unsigned rand_sep();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return 8'h20;
        if (pick < 7) return 8'h0A;
        if (pick < 8) return 8'h09;
        // any non-digit
        do pick = $urandom_range(0, 255); while (pick >= CH_ZERO && pick <= CH_NINE);
        return pick;
    endfunction

    function automatic void put_number(int unsigned v);
        string s;
        s.itoa(v);
        put_text(s);
        put_byte(rand_sep());
    endfunction

    function automatic void put_random_file();
        int unsigned w, h, mx, kind, n, v, lim;
        bit ascii;
        kind = $urandom_range(0, 19);
        ascii = 1'($urandom_range(0, 1));
        w = $urandom_range(1, 4);
        h = $urandom_range(1, 3);
        mx = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) :
             ($urandom_range(0, 1) ? 255 : $urandom_range(1, 15));
        if (ascii && $urandom_range(0, 5) == 0) mx = $urandom_range(256, 65535);
        put_byte(kind == 0 ? $urandom_range(0, 255) : CH_P, 1);
        put_byte(kind == 1 ? $urandom_range(0, 255) : (ascii ? CH_THREE : CH_SIX));
        put_number(kind == 2 ? 0 : w);
        put_number(h);
        put_number(kind == 3 ? 0 : mx);
        n = 3 * w * h + ((kind == 4) ? $urandom_range(1, 6) : 0);
        if (kind == 5) n = $urandom_range(0, 3 * w * h);
        lim = ascii ? mx + mx / 4 + 1 : 255;
        if (lim > 65535) lim = 65535;
        for (int i = 0; i < n; i++) begin
            v = ($urandom_range(0, 7) == 0) ? lim : $urandom_range(0, lim);
            if (ascii) put_number(v);
            else put_byte(v);
        end
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                decode_byte('{i_file_byte, i_start_of_file});
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (byte_q.size() > 0 && !hold_send) begin
                    if (!quiet_tail && $urandom_range(0, 15) == 0) begin
                        send_gap <= $urandom_range(1, 19) - 1;
                        i_valid <= 1'b0;
                    end else begin
                        t_in_item it;
                        it = byte_q.pop_front();
                        i_file_byte <= it.fbyte;
                        i_start_of_file <= it.sof;
                        i_valid <= 1'b1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int stall_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pixel_q.size() == 0) begin
                    $error("pixel with no expectation: r=%0d g=%0d b=%0d",
                           o_red, o_green, o_blue);
                    n_errors++;
                end else begin
                    t_pixel px;
                    px = pixel_q.pop_front();
                    if (o_red !== px.red) begin
                        $error("red exp %0d got %0d", px.red, o_red); n_errors++;
                    end
                    if (o_green !== px.green) begin
                        $error("green exp %0d got %0d", px.green, o_green); n_errors++;
                    end
                    if (o_blue !== px.blue) begin
                        $error("blue exp %0d got %0d", px.blue, o_blue); n_errors++;
                    end
                    if (o_final_pixel !== px.last) begin
                        $error("final_pixel exp %0d got %0d", px.last, o_final_pixel);
                        n_errors++;
                    end
                    if (o_ascii_format !== px.ascii) begin
                        $error("ascii_format exp %0d got %0d", px.ascii, o_ascii_format);
                        n_errors++;
                    end
                end
            end
            if (stall_gap > 0) begin
                stall_gap <= stall_gap - 1;
                i_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
                stall_gap <= $urandom_range(1, 19) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        // directed files
        put_text("P3 2 2 255 0 0 0 255 255 255 1 2 3 254 128 7 ", 1);
        put_text("P6 1 1 255 ", 1);
        put_byte(8'hFF); put_byte(8'h00); put_byte(8'h80); put_byte(8'h11);
        put_text("P3 1 1 1 2 0 1 ", 1);
        put_text("Q3 1 1 1 1 1 1 ", 1);
        put_text("P5 1 1 1 ", 1);
        put_text("P6 1 1 256 ", 1);
        put_text("P3 0 1 1 ", 1);
        put_text("P3 99999 1 99999999 99999 0 65535x", 1);
        put_text("P6 1 1 0 ", 1);
        put_text("P3 1 1 7 7 7 7", 1);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender hold-off until drained
        wait (byte_q.size() == 0);
        hold_send = 1'b1;
        do @(negedge i_clk); while (i_valid || pixel_q.size() != 0);
        repeat (40) @(posedge i_clk);
        hold_send = 1'b0;

        while (n_items < 1120) begin
            put_random_file();
            if (n_items > 1000) quiet_tail = 1'b1;
            wait (byte_q.size() < 40);
        end

        wait (byte_q.size() == 0);
        do @(negedge i_clk); while (i_valid || pixel_q.size() != 0);
        repeat (60) @(posedge i_clk);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycle_cnt > 400000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

FILE: filelist.f
hdl/ppmd_pkg.sv
hdl/ppmd_front.sv
hdl/ppmd_fifo.sv
hdl/ppmd_back.sv
hdl/ppm_image_stream_decoder_top.sv
test/tb_ppm_image_stream_decoder_top.sv
